// File: rtl/mtr_pkg.sv
package mtr_pkg;

    // Packet kind codes
    localparam logic [1:0] FUNC_VIDEO = 2'd0;
    localparam logic [1:0] FUNC_AUDIO = 2'd1;
    localparam logic [1:0] FUNC_OTHER = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_STEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_AMOUNT   = 2'd3;

    localparam int unsigned CFG_DATA_W = 27;
    localparam int unsigned STAMP_W    = 64;

    // Reset values of the configuration registers
    localparam logic [23:0] JUMP_LIMIT_RST    = 24'd30000;
    localparam logic [26:0] REVERSE_LIMIT_RST = 27'd300000;
    localparam logic [9:0]  GAP_STEP_RST      = 10'd30;
    localparam logic [9:0]  TRIM_AMOUNT_RST   = 10'd5;

    typedef struct packed {
        logic [23:0] jump_limit;
        logic [26:0] reverse_limit;
        logic [9:0]  gap_step;
        logic [9:0]  trim_amount;
    } t_cfg;

    // Per-channel timeline state
    typedef struct packed {
        logic [STAMP_W-1:0] base;
        logic               started;
        logic [STAMP_W-1:0] prev_in;
    } t_chan;

endpackage

// File: rtl/media_timestamp_rebaser.sv
// Rebases video and audio packet timestamps onto one continuous output
// timeline. One packet is taken per clock cycle unless the result is stalled;
// its result passes through the input register, then the result register; the
// per-channel base and last-stamp registers are updated as a packet leaves the
// compute stage, so back-to-back packets of one channel see each other's update.
// A stalled result holds the compute stage, which holds the input register.
// Packets tagged other (or kind 3) are consumed without a result. The
// configuration port always accepts; write it only while no packet is in
// flight.
module media_timestamp_rebaser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic signed [mtr_pkg::STAMP_W-1:0]  i_in_stamp,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mtr_pkg::STAMP_W-1:0]  o_out_stamp,
    output logic                                o_is_audio,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mtr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mtr_pkg::*;

    t_cfg               cfg;
    logic               r_in_valid;
    logic [1:0]         r_in_func;
    logic [STAMP_W-1:0] r_in_stamp;
    t_chan              r_video;
    t_chan              r_audio;
    t_chan              n_video;
    t_chan              n_audio;
    logic               r_out_valid;
    logic [STAMP_W-1:0] r_out_stamp;
    logic               r_out_audio;
    logic               calc_has_result;
    logic               calc_is_audio;
    logic [STAMP_W-1:0] calc_stamp;
    logic               advance;

    mtr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mtr_rebase_calc u_calc (
        .i_cfg        (cfg),
        .i_video      (r_video),
        .i_audio      (r_audio),
        .i_func       (r_in_func),
        .i_stamp      (r_in_stamp),
        .o_video      (n_video),
        .o_audio      (n_audio),
        .o_has_result (calc_has_result),
        .o_is_audio   (calc_is_audio),
        .o_out_stamp  (calc_stamp)
    );

    // Move the compute stage on when the result register is free or drains
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    // Input register: load on transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func  <= i_func;
            r_in_stamp <= STAMP_W'(i_in_stamp);
        end
    end

    // Channel state: commit the update as the item leaves the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video <= '0;
            r_audio <= '0;
        end else if (r_in_valid && advance) begin
            r_video <= n_video;
            r_audio <= n_audio;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && calc_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && calc_has_result) begin
            r_out_stamp <= calc_stamp;
            r_out_audio <= calc_is_audio;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_stamp = $signed(r_out_stamp);
    assign o_is_audio  = r_out_audio;

`ifndef SYNTHESIS
    a_video_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && (r_in_func == FUNC_VIDEO)) |=> r_video.started)
        else $error("video channel not started after a video item");

    a_audio_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && (r_in_func == FUNC_AUDIO)) |=> r_audio.started)
        else $error("audio channel not started after an audio item");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_stamp)
                                      && $stable(r_in_func)))
        else $error("input register changed while stalled");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && ((r_in_func == FUNC_VIDEO)
                                                    || (r_in_func == FUNC_AUDIO))))
        else $error("result without a video or audio item");
`endif

endmodule

// File: rtl/mtr_cfg_regs.sv
module mtr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mtr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mtr_pkg::t_cfg                    o_cfg
);
    import mtr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write index and take the low bits of the data
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_JUMP_LIMIT:    n_cfg.jump_limit    = i_cfg_data[23:0];
                CFG_REVERSE_LIMIT: n_cfg.reverse_limit = i_cfg_data[26:0];
                CFG_GAP_STEP:      n_cfg.gap_step      = i_cfg_data[9:0];
                CFG_TRIM_AMOUNT:   n_cfg.trim_amount   = i_cfg_data[9:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_limit    <= JUMP_LIMIT_RST;
            r_cfg.reverse_limit <= REVERSE_LIMIT_RST;
            r_cfg.gap_step      <= GAP_STEP_RST;
            r_cfg.trim_amount   <= TRIM_AMOUNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// File: rtl/mtr_rebase_calc.sv
module mtr_rebase_calc (
    input  mtr_pkg::t_cfg                i_cfg,
    input  mtr_pkg::t_chan               i_video,
    input  mtr_pkg::t_chan               i_audio,
    input  logic [1:0]                   i_func,
    input  logic [mtr_pkg::STAMP_W-1:0]  i_stamp,
    output mtr_pkg::t_chan               o_video,
    output mtr_pkg::t_chan               o_audio,
    output logic                         o_has_result,
    output logic                         o_is_audio,
    output logic [mtr_pkg::STAMP_W-1:0]  o_out_stamp
);
    import mtr_pkg::*;

    logic               is_audio;
    t_chan              cur;
    t_chan              oth;
    t_chan              nxt;
    logic [STAMP_W-1:0] diff_fwd;
    logic [STAMP_W-1:0] diff_back;
    logic [STAMP_W-1:0] gap;
    logic [STAMP_W-1:0] trim;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W-1:0] out_delta;
    logic               fwd;
    logic               fwd_small;
    logic               rev_big;

    // Pick the channel being served and the opposite one
    assign is_audio = (i_func == FUNC_AUDIO);
    assign cur      = is_audio ? i_audio : i_video;
    assign oth      = is_audio ? i_video : i_audio;

    // Step magnitude in both directions, compared unsigned against the limits
    assign diff_fwd  = i_stamp - cur.prev_in;
    assign diff_back = cur.prev_in - i_stamp;
    assign fwd       = ($signed(i_stamp) >= $signed(cur.prev_in));
    assign fwd_small = (diff_fwd < STAMP_W'(i_cfg.jump_limit));
    assign rev_big   = (diff_back > STAMP_W'(i_cfg.reverse_limit));
    assign gap       = STAMP_W'(i_cfg.gap_step);
    assign trim      = STAMP_W'(i_cfg.trim_amount);

    always_comb begin
        if (fwd) begin
            delta = fwd_small ? diff_fwd : gap;
        end else begin
            delta = rev_big ? gap : '0;
        end
        out_delta = (delta > trim) ? (delta - trim) : delta;
    end

    // Start a fresh channel from the other base (zero if unstarted), else advance the base
    always_comb begin
        nxt.started = 1'b1;
        nxt.prev_in = i_stamp;
        if (!cur.started) begin
            nxt.base    = oth.started ? oth.base : '0;
            o_out_stamp = nxt.base;
        end else begin
            nxt.base    = cur.base + delta;
            o_out_stamp = cur.base + out_delta;
        end
    end

    assign o_has_result = (i_func == FUNC_VIDEO) || (i_func == FUNC_AUDIO);
    assign o_is_audio   = is_audio;
    assign o_video      = (i_func == FUNC_VIDEO) ? nxt : i_video;
    assign o_audio      = is_audio ? nxt : i_audio;

endmodule
